// ===== rtl/mrdc_pkg.sv =====
`timescale 1ns / 1ps

package mrdc_pkg;

  localparam int COORD_BITS = 13;
  localparam int CFG_BITS   = 14;
  localparam int THR_BITS   = 13;
  localparam int IDX_BITS   = 2;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(1920);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(1080);
  localparam logic [THR_BITS-1:0] DIR_THR_RST      = THR_BITS'(20);
  localparam logic [THR_BITS-1:0] QUIET_THR_RST    = THR_BITS'(5);

  localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_DIR_THR      = 2'd2;
  localparam logic [IDX_BITS-1:0] CFG_QUIET_THR    = 2'd3;

  localparam logic OP_BOX       = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_RIGHT = 2'b01;
  localparam logic [1:0] DIR_LEFT  = 2'b10;

  localparam logic [1:0] REGION_LEFT  = 2'b01;
  localparam logic [1:0] REGION_RIGHT = 2'b10;

  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] box_start_x;
    logic [COORD_BITS-1:0] box_start_y;
    logic [COORD_BITS-1:0] box_end_x;
    logic [COORD_BITS-1:0] box_end_y;
    logic                  box_shaking;
    logic [COORD_BITS-1:0] roi_start_x;
    logic [COORD_BITS-1:0] roi_end_x;
    logic [COORD_BITS-1:0] target_start_x;
    logic [COORD_BITS-1:0] target_end_x;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motion_region;
    logic [1:0] motion_direction;
  } out_item_t;

endpackage

// ===== rtl/motion_region_direction_classifier.sv =====
`timescale 1ns / 1ps

// motion region and direction classifier
//
// input channel (in_valid / in_stall / in_data) takes one transaction per
// cycle when not stalled: an object box (opcode box) or an end of frame
// (opcode frame end). boxes not flagged as shaking are tested against the
// left and right bands and ORed into a region mask; they produce no output
// transaction. an end of frame produces one output transaction (out_valid /
// out_stall / out_data) with the region mask and a motion direction, then
// clears the mask. out_valid rises once the frame end has passed the input
// register and then the result register. throughput: one transaction per
// cycle, limited only by the single result register when the receiver stalls.
// when out_stall holds the result, further boxes are still absorbed; an end
// of frame waits in the input register and in_stall rises behind it.
// config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready
// and must be written only while the block is idle (not enforced by the block).
// reset (rst_n low, synchronous) restores register defaults, clears the mask,
// the previous region and the first-frame flag, and empties the pipeline.
module motion_region_direction_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mrdc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mrdc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrdc_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [mrdc_pkg::CFG_BITS-1:0]       cfg_data
);
  import mrdc_pkg::*;

  function automatic logic [COORD_BITS-1:0] centre(input logic [COORD_BITS-1:0] s,
                                                   input logic [COORD_BITS-1:0] e);
    logic [COORD_BITS:0] sum;
    sum = {1'b0, s} + {1'b0, e} + (COORD_BITS+1)'(1);
    return sum[COORD_BITS:1];
  endfunction

  logic [CFG_BITS-1:0]   frame_width_r, frame_height_r;
  logic [THR_BITS-1:0]   dir_thr_r, quiet_thr_r;
  in_item_t              in_r;
  logic                  s1_valid_r, s1_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            region_mask_r, region_mask_nxt;
  logic                  seen_r;
  logic [COORD_BITS-1:0] prev_roi_sx_r, prev_roi_ex_r;

  logic                  in_accept, s1_is_end, out_free, s1_go, fe_go, box_go;
  logic [CFG_BITS-3:0]   mid;
  logic                  box_ok, left_hit, right_hit;
  logic [COORD_BITS-1:0] c_prev, c_tar, c_cur, d_mag, d1_mag;
  logic                  tar_gt, cur_neg, moving, quiet;
  logic [1:0]            dir;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign s1_is_end = (in_r.opcode == OP_FRAME_END);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_is_end || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign fe_go     = s1_go && s1_is_end;
  assign box_go    = s1_go && !s1_is_end && !in_r.box_shaking;

  // band tests
  always_comb begin
    mid    = frame_width_r[CFG_BITS-1:2];
    box_ok = (in_r.box_start_x <= in_r.box_end_x) && (in_r.box_start_y <= in_r.box_end_y)
             && ({1'b0, in_r.box_start_y} <= frame_height_r);
    left_hit  = box_ok && ({1'b0, in_r.box_start_x} < {2'b00, mid});
    right_hit = box_ok && ({2'b00, mid} <= {1'b0, in_r.box_end_x})
                && ({1'b0, in_r.box_start_x} < frame_width_r);
  end

  // direction
  always_comb begin
    c_prev  = centre(prev_roi_sx_r, prev_roi_ex_r);
    c_tar   = centre(in_r.target_start_x, in_r.target_end_x);
    c_cur   = centre(in_r.roi_start_x, in_r.roi_end_x);
    tar_gt  = c_tar > c_prev;
    d_mag   = tar_gt ? (c_tar - c_prev) : (c_prev - c_tar);
    cur_neg = c_cur < c_prev;
    d1_mag  = cur_neg ? (c_prev - c_cur) : (c_cur - c_prev);
    moving  = d_mag > dir_thr_r;
    quiet   = d1_mag < quiet_thr_r;
    dir     = DIR_NONE;
    if (seen_r && moving && !quiet) begin
      if (tar_gt && !cur_neg) begin
        dir = DIR_RIGHT;
      end else if (!tar_gt && cur_neg) begin
        dir = DIR_LEFT;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (fe_go) begin
      out_valid_nxt            = 1'b1;
      out_nxt.motion_region    = region_mask_r;
      out_nxt.motion_direction = dir;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    region_mask_nxt = region_mask_r;
    if (fe_go) begin
      region_mask_nxt = 2'b00;
    end else if (box_go) begin
      region_mask_nxt = region_mask_r | (left_hit ? REGION_LEFT : 2'b00)
                        | (right_hit ? REGION_RIGHT : 2'b00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      dir_thr_r      <= DIR_THR_RST;
      quiet_thr_r    <= QUIET_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_DIR_THR:      dir_thr_r      <= cfg_data[THR_BITS-1:0];
        CFG_QUIET_THR:    quiet_thr_r    <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      region_mask_r <= 2'b00;
      seen_r        <= 1'b0;
      prev_roi_sx_r <= '0;
      prev_roi_ex_r <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      region_mask_r <= region_mask_nxt;
      if (fe_go) begin
        seen_r        <= 1'b1;
        prev_roi_sx_r <= in_r.roi_start_x;
        prev_roi_ex_r <= in_r.roi_end_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_end_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    fe_go |=> out_valid)
    else $error("frame end did not produce a result");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r && in_r.opcode == OP_FRAME_END))
    else $error("result without a frame end");

  a_mask_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fe_go |=> region_mask_r == 2'b00)
    else $error("region mask not cleared after frame end");

  a_first_frame_none: assert property (@(posedge clk) disable iff (!rst_n)
    fe_go && !seen_r |=> out_data.motion_direction == DIR_NONE)
    else $error("first frame reported a direction");

endmodule
